// ===== rtl/priority_array_command_arbiter_unit_macros.svh =====
// Assertion macros shared by the priority array arbiter RTL.
`ifndef PRIORITY_ARRAY_COMMAND_ARBITER_UNIT_MACROS_SVH
`define PRIORITY_ARRAY_COMMAND_ARBITER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PACU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pacu: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PACU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pacu: assertion failed");

`endif

// ===== rtl/pacu_pkg.sv =====
// Package: shared types, codes and defaults of the priority array arbiter.
`timescale 1ns / 1ps
package pacu_pkg;

  localparam int OBJECT_COUNT_DEF    = 4;
  localparam int PRIORITY_LEVELS_DEF = 16;

  localparam int LEVEL_W  = 8;
  localparam int INST_W   = 8;
  localparam int PRIO_W   = 5;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_READ    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELINQ  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_INSTANCE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PRIORITY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LEVEL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DENIED       = 3'd4;

  localparam logic [PRIO_W-1:0] DENIED_PRIORITY = 5'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELINQ_DEF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DENY_PRIO6   = 2'd2;

  localparam logic [LEVEL_W-1:0] NUM_STATES_RST = 8'd3;
  localparam logic [LEVEL_W-1:0] RELINQ_DEF_RST = 8'd1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INST_W-1:0]  inst;
    logic [PRIO_W-1:0]  prio;
    logic [LEVEL_W-1:0] level;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] num_states;
    logic [LEVEL_W-1:0] relinq_def;
    logic               deny_prio6;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  pv;
    logic [PRIO_W-1:0]   win;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

// ===== rtl/priority_array_command_arbiter_unit.sv =====
// Top level: priority array command arbiter with registered stage and result.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in      | input     | in_valid / in_stall | mode, instance_req, priority_req, level
//   out     | output    | out_valid/out_stall | present_value, winning_priority, status
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// One transaction per cycle while out_stall is low; a result passes the stage register, then the result register.
// The throughput is set by the single row read-modify-write per cycle on the slot RAM,
// with a same-edge bypass covering back-to-back hits on one object.
// Reset clears per-object row-valid flops: no clearing pass, all slots empty.
// out_stall holds the result register; the stage behind it then fills and in_stall rises.
`timescale 1ns / 1ps
`include "priority_array_command_arbiter_unit_macros.svh"
module priority_array_command_arbiter_unit #(
  parameter int OBJECT_COUNT    = pacu_pkg::OBJECT_COUNT_DEF,
  parameter int PRIORITY_LEVELS = pacu_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pacu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pacu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pacu_pkg::MODE_W-1:0]        in_mode,
  input  logic [pacu_pkg::INST_W-1:0]        in_instance_req,
  input  logic [pacu_pkg::PRIO_W-1:0]        in_priority_req,
  input  logic [pacu_pkg::LEVEL_W-1:0]       in_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pacu_pkg::LEVEL_W-1:0]       out_present_value,
  output logic [pacu_pkg::PRIO_W-1:0]        out_winning_priority,
  output logic [pacu_pkg::STATUS_W-1:0]      out_status
);
  import pacu_pkg::*;

  localparam int IDX_W = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
  localparam int ROW_W = PRIORITY_LEVELS * (LEVEL_W + 1);

  // configuration registers
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_states <= NUM_STATES_RST;
      cfg_r.relinq_def <= RELINQ_DEF_RST;
      cfg_r.deny_prio6 <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_STATES: cfg_r.num_states <= cfg_wdata;
        CFG_RELINQ_DEF: cfg_r.relinq_def <= cfg_wdata;
        CFG_DENY_PRIO6: cfg_r.deny_prio6 <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc;
  logic out_free;
  logic s1_adv;
  logic in_inst_ok;

  logic s1_valid_r;
  logic s1_inst_ok_r;
  req_t s1_req_r;

  logic out_valid_r;
  res_t out_res_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign s1_adv     = s1_valid_r && out_free;
  assign in_stall   = s1_valid_r && !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign in_inst_ok = (in_instance_req < INST_W'(OBJECT_COUNT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.mode  <= in_mode;
      s1_req_r.inst  <= in_instance_req;
      s1_req_r.prio  <= in_priority_req;
      s1_req_r.level <= in_level;
      s1_inst_ok_r   <= in_inst_ok;
    end
  end

  // slot store and command logic
  logic             st_wr_en;
  logic             cmd_wr_en;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] new_row;
  res_t             cmd_res;

  // RAM writes only when the transaction leaves the stage, so it happens once
  assign st_wr_en = s1_adv && cmd_wr_en;

  pacu_store #(
    .OBJECT_COUNT    (OBJECT_COUNT),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc && in_inst_ok),
    .rd_idx (in_instance_req[IDX_W-1:0]),
    .wr_en  (st_wr_en),
    .wr_idx (s1_req_r.inst[IDX_W-1:0]),
    .wr_row (new_row),
    .rd_row (rd_row)
  );

  pacu_cmd #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_cmd (
    .req     (s1_req_r),
    .inst_ok (s1_inst_ok_r),
    .cfg     (cfg_r),
    .row     (rd_row),
    .wr_en   (cmd_wr_en),
    .new_row (new_row),
    .res     (cmd_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= cmd_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_present_value    = out_res_r.pv;
  assign out_winning_priority = out_res_r.win;
  assign out_status           = out_res_r.status;

  // checks
  `PACU_ASSERT_NXT(a_adv_loads_out, s1_adv, out_valid_r)
  `PACU_ASSERT_NXT(a_bad_inst_result, s1_adv && !s1_inst_ok_r,
                   out_status == ST_BAD_INSTANCE && out_winning_priority == '0)
  `PACU_ASSERT_IMP(a_stall_only_full, in_stall, s1_valid_r && out_valid_r)
  `PACU_ASSERT_IMP(a_win_in_range, out_valid_r,
                   out_winning_priority <= PRIO_W'(PRIORITY_LEVELS))

endmodule

// ===== rtl/pacu_store.sv =====
// Command slot store: one row per object, row-valid flops, same-edge bypass.
`timescale 1ns / 1ps
module pacu_store #(
  parameter int OBJECT_COUNT    = pacu_pkg::OBJECT_COUNT_DEF,
  parameter int PRIORITY_LEVELS = pacu_pkg::PRIORITY_LEVELS_DEF,
  localparam int IDX_W = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1,
  localparam int ROW_W = PRIORITY_LEVELS * (pacu_pkg::LEVEL_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [ROW_W-1:0] wr_row,
  output logic [ROW_W-1:0] rd_row
);
  import pacu_pkg::*;

  logic [ROW_W-1:0]        mem [OBJECT_COUNT];
  logic [ROW_W-1:0]        mem_q_r;
  logic [ROW_W-1:0]        byp_row_r;
  logic [OBJECT_COUNT-1:0] row_vld_r;
  logic                    rd_vld_r;
  logic                    byp_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en) begin
      mem_q_r   <= mem[rd_idx];
      byp_row_r <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
      byp_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= row_vld_r[rd_idx];
        // write landing on the same row at the read edge: RAM returns old data
        byp_hit_r <= wr_en && (wr_idx == rd_idx);
      end
    end
  end

  // never-written row reads as all slots empty
  assign rd_row = byp_hit_r ? byp_row_r : (rd_vld_r ? mem_q_r : '0);

endmodule

// ===== rtl/pacu_cmd.sv =====
// Command checks, slot update and priority resolution for one object row.
`timescale 1ns / 1ps
module pacu_cmd #(
  parameter int PRIORITY_LEVELS = pacu_pkg::PRIORITY_LEVELS_DEF,
  localparam int ROW_W  = PRIORITY_LEVELS * (pacu_pkg::LEVEL_W + 1),
  localparam int SLOT_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1
) (
  input  pacu_pkg::req_t   req,
  input  logic             inst_ok,
  input  pacu_pkg::cfg_t   cfg,
  input  logic [ROW_W-1:0] row,
  output logic             wr_en,
  output logic [ROW_W-1:0] new_row,
  output pacu_pkg::res_t   res
);
  import pacu_pkg::*;

  logic              is_cmd;
  logic              is_wr;
  logic [STATUS_W-1:0] status;
  logic [PRIO_W-1:0] prio_m1;
  logic [SLOT_W-1:0] slot;

  assign is_wr   = (req.mode == MODE_WRITE);
  assign is_cmd  = is_wr || (req.mode == MODE_RELINQ);
  assign prio_m1 = req.prio - 5'd1;
  assign slot    = prio_m1[SLOT_W-1:0];

  always_comb begin
    status = ST_OK;
    if (!inst_ok) begin
      status = ST_BAD_INSTANCE;
    end else if (is_cmd) begin
      if ((req.prio == '0) || (req.prio > PRIO_W'(PRIORITY_LEVELS))) begin
        status = ST_BAD_PRIORITY;
      end else if ((req.prio == DENIED_PRIORITY) && cfg.deny_prio6) begin
        status = ST_DENIED;
      end else if (is_wr && ((req.level == '0) || (req.level > cfg.num_states))) begin
        status = ST_BAD_LEVEL;
      end
    end
  end

  assign wr_en = inst_ok && is_cmd && (status == ST_OK);

  // row layout: {levels, valid mask}; slot k level at [PL + 8k +: 8]
  always_comb begin
    new_row = row;
    if (wr_en) begin
      for (int k = 0; k < PRIORITY_LEVELS; k++) begin
        if (slot == SLOT_W'(k)) begin
          new_row[k] = is_wr;
          new_row[PRIORITY_LEVELS + k*LEVEL_W +: LEVEL_W] = is_wr ? req.level : '0;
        end
      end
    end
  end

  // lowest-numbered occupied slot wins
  always_comb begin
    res.pv     = cfg.relinq_def;
    res.win    = '0;
    res.status = status;
    if (inst_ok) begin
      for (int k = PRIORITY_LEVELS - 1; k >= 0; k--) begin
        if (new_row[k]) begin
          res.pv  = new_row[PRIORITY_LEVELS + k*LEVEL_W +: LEVEL_W];
          res.win = PRIO_W'(k + 1);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the priority array command arbiter.
`timescale 1ns / 1ps
module tb_top;
  import pacu_pkg::*;

  localparam int OBJ_N  = OBJECT_COUNT_DEF;
  localparam int PRIO_N = PRIORITY_LEVELS_DEF;
  // Mode code 3 has no function of its own; the block treats it as a read.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int HOLD_CYCLES = 40;

  // Priority array model plus queue of pending present-value results.
  class pv_scoreboard;
    bit                 slot_full  [OBJ_N][PRIO_N];
    logic [LEVEL_W-1:0] slot_level [OBJ_N][PRIO_N];
    logic [LEVEL_W-1:0] num_states;
    logic [LEVEL_W-1:0] relinq_def;
    bit                 deny6;
    res_t               expected_q[$];
    int                 errors;

    function new();
      foreach (slot_full[o, p]) begin
        slot_full[o][p]  = 1'b0;
        slot_level[o][p] = '0;
      end
      num_states = NUM_STATES_RST;
      relinq_def = RELINQ_DEF_RST;
      deny6      = 1'b1;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_STATES: num_states = data;
        CFG_RELINQ_DEF: relinq_def = data;
        CFG_DENY_PRIO6: deny6      = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command and queue the resolution it should produce.
    function void note_request(req_t r);
      res_t                e;
      logic [STATUS_W-1:0] st;
      if (r.inst >= OBJ_N) begin
        e.pv     = relinq_def;
        e.win    = '0;
        e.status = ST_BAD_INSTANCE;
      end else begin
        st = ST_OK;
        if (r.mode == MODE_WRITE || r.mode == MODE_RELINQ) begin
          if (r.prio < 1 || r.prio > PRIO_N)
            st = ST_BAD_PRIORITY;
          else if (r.prio == DENIED_PRIORITY && deny6)
            st = ST_DENIED;
          else if (r.mode == MODE_WRITE && (r.level < 1 || r.level > num_states))
            st = ST_BAD_LEVEL;
          if (st == ST_OK) begin
            slot_full[r.inst][r.prio - 1]  = (r.mode == MODE_WRITE);
            slot_level[r.inst][r.prio - 1] = (r.mode == MODE_WRITE) ? r.level : '0;
          end
        end
        // Lowest-numbered occupied slot wins, else the default applies.
        e.pv  = relinq_def;
        e.win = '0;
        for (int p = PRIO_N - 1; p >= 0; p--) begin
          if (slot_full[r.inst][p]) begin
            e.pv  = slot_level[r.inst][p];
            e.win = PRIO_W'(p + 1);
          end
        end
        e.status = st;
      end
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no transaction pending", $realtime);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.pv !== want.pv)         report_mismatch("present_value", got.pv, want.pv);
        if (got.win !== want.win)       report_mismatch("winning_priority", got.win, want.win);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [INST_W-1:0]    in_instance_req = '0;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic [LEVEL_W-1:0]   in_level = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [LEVEL_W-1:0]   out_present_value;
  logic [PRIO_W-1:0]    out_winning_priority;
  logic [STATUS_W-1:0]  out_status;

  pv_scoreboard sb;

  // Idle rates in percent, changed per phase by the stimulus sequence.
  int gap_pct   = 8;
  int stall_pct = 68;
  // Long receiver hold-offs: the sequence bumps hold_requests, the receiver
  // process counts out the stall on its own.
  int hold_requests = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  priority_array_command_arbiter_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_mode              (in_mode),
    .in_instance_req      (in_instance_req),
    .in_priority_req      (in_priority_req),
    .in_level             (in_level),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_present_value    (out_present_value),
    .out_winning_priority (out_winning_priority),
    .out_status           (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stall, or a long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (hold_left == 0 && hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: all values seen here are the ones sampled at this edge.
  // Input is noted before the output check so a same-edge result would still line up.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en)
        sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        sb.note_request('{mode: in_mode, inst: in_instance_req,
                          prio: in_priority_req, level: in_level});
      if (out_valid && !out_stall)
        sb.check_result('{pv: out_present_value, win: out_winning_priority,
                          status: out_status});
    end
  end

  // Present one command and hold it until the block takes it.
  task automatic send_request(logic [MODE_W-1:0] mode, logic [INST_W-1:0] inst,
                              logic [PRIO_W-1:0] prio, logic [LEVEL_W-1:0] lvl);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_instance_req <= inst;
    in_priority_req <= prio;
    in_level        <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly legal commands on valid objects so the slot arrays fill and empty;
  // a minority hits bad instances, bad priorities and out-of-range levels.
  task automatic send_random_request();
    logic [MODE_W-1:0]  mode;
    logic [INST_W-1:0]  inst;
    logic [PRIO_W-1:0]  prio;
    logic [LEVEL_W-1:0] lvl;
    int                 sel;
    sel  = $urandom_range(99);
    mode = (sel < 40) ? MODE_WRITE : (sel < 65) ? MODE_RELINQ :
           (sel < 94) ? MODE_READ : MODE_SPARE;
    inst = ($urandom_range(99) < 90) ? INST_W'($urandom_range(OBJ_N - 1)) :
                                       INST_W'($urandom_range(255));
    prio = ($urandom_range(99) < 85) ? PRIO_W'($urandom_range(PRIO_N, 1)) :
                                       PRIO_W'($urandom_range(31));
    if ($urandom_range(99) < 85 && sb.num_states != 0)
      lvl = LEVEL_W'($urandom_range(sb.num_states, 1));
    else
      lvl = LEVEL_W'($urandom_range(255));
    send_request(mode, inst, prio, lvl);
  endtask

  // Drop valid and wait until every result is back, plus a short settle.
  // The first edge lets the monitor note a transaction accepted at this edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; enable stays high throughout.
  task automatic set_config(logic [LEVEL_W-1:0] ns, logic [LEVEL_W-1:0] rd,
                            logic [CFG_DATA_W-1:0] deny_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_NUM_STATES;
    cfg_wdata <= ns;
    @(posedge clk);
    cfg_index <= CFG_RELINQ_DEF;
    cfg_wdata <= rd;
    @(posedge clk);
    cfg_index <= CFG_DENY_PRIO6;
    cfg_wdata <= deny_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int n, int gap, int stall, logic [LEVEL_W-1:0] ns,
                           logic [LEVEL_W-1:0] rd, logic [CFG_DATA_W-1:0] deny_word,
                           bit with_hold);
    drain();
    set_config(ns, rd, deny_word);
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3)
        hold_requests++;
      send_random_request();
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset configuration: 3 states, default 1, priority 6 denied.
    send_request(MODE_READ,   8'd0,   5'd0,  8'd0);    // empty array gives default
    send_request(MODE_READ,   8'd255, 5'd31, 8'd255);  // top instance invalid
    send_request(MODE_READ,   INST_W'(OBJ_N), 5'd1, 8'd1);  // first invalid instance
    send_request(MODE_WRITE,  8'd0,   5'd0,  8'd1);    // priority below range
    send_request(MODE_WRITE,  8'd0,   5'd17, 8'd1);    // priority above range
    send_request(MODE_WRITE,  8'd0,   5'd31, 8'd2);
    send_request(MODE_WRITE,  8'd0,   DENIED_PRIORITY, 8'd2);
    send_request(MODE_RELINQ, 8'd0,   DENIED_PRIORITY, 8'd0);
    send_request(MODE_WRITE,  8'd0,   5'd3,  8'd0);    // level zero
    send_request(MODE_WRITE,  8'd0,   5'd3,  8'd4);    // level above state count
    send_request(MODE_WRITE,  8'd0,   5'd16, 8'd3);    // lowest priority slot
    send_request(MODE_WRITE,  8'd0,   5'd1,  8'd1);    // highest priority wins
    send_request(MODE_WRITE,  8'd3,   5'd8,  8'd2);
    send_request(MODE_SPARE,  8'd3,   5'd31, 8'd255);  // spare mode reads
    send_request(MODE_RELINQ, 8'd0,   5'd1,  8'd0);    // falls back to slot 16
    send_request(MODE_RELINQ, 8'd0,   5'd5,  8'd0);    // empty slot, still ok
    send_request(MODE_RELINQ, 8'd0,   5'd0,  8'd0);
    send_request(MODE_WRITE,  8'd128, 5'd2,  8'd2);    // bad instance, no change
    send_request(MODE_WRITE,  8'd1,   DENIED_PRIORITY, 8'd5);  // denial before level
    send_request(MODE_WRITE,  8'd1,   5'd0,  8'd0);    // priority before level

    // Zero states rejects every write; default 0 is returned as written.
    drain();
    set_config(8'd0, 8'd0, 8'd0);
    send_request(MODE_WRITE,  8'd1,   DENIED_PRIORITY, 8'd1);
    send_request(MODE_RELINQ, 8'd1,   DENIED_PRIORITY, 8'd0);
    send_request(MODE_READ,   8'd2,   5'd0,  8'd0);
    send_request(MODE_READ,   8'd200, 5'd0,  8'd0);

    drain();
    set_config(8'd255, 8'd255, 8'd0);
    send_request(MODE_WRITE,  8'd2,   DENIED_PRIORITY, 8'd255);

    // Random phases: slow receiver, slow sender, then back to back.
    run_phase(550, 8, 68, 8'd255, LEVEL_W'($urandom_range(255, 1)), 8'h00, 1'b1);
    run_phase(550, 68, 8, LEVEL_W'($urandom_range(16, 2)), 8'd255, 8'h01, 1'b0);
    run_phase(275, 0, 0, 8'd1, 8'd1, 8'hFE, 1'b1);
    run_phase(275, 0, 0, LEVEL_W'($urandom_range(255, 1)), LEVEL_W'($urandom_range(255)),
              8'hFF, 1'b1);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
